/* hdl/rational_arith_unit_macros.svh */
// assertion macros for the rational arithmetic unit
// used by rational_arith_unit.sv; expects clk_i and rst_ni in scope
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// plain property checked every clock outside reset
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rau_pkg.sv */
// shared types and codes of the rational arithmetic unit
// no dependencies
package rau_pkg;

  localparam int unsigned ValueBits = 32;

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;
  localparam logic [2:0] OpLt  = 3'd4;
  localparam logic [2:0] OpEq  = 3'd5;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StZeroDen = 2'd1;
  localparam logic [1:0] StDivZero = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_GTWO, S_GXODD, S_GLOOP, S_GSHL,
    S_DIV, S_NEXT, S_MLOAD, S_MUL, S_COMB, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_A, PH_B, PH_R
  } phase_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               cmp_true;
    logic [1:0]         status;
  } out_t;

endpackage

/* hdl/rational_arith_unit.sv */
// Rational arithmetic unit: add, subtract, multiply, divide and compare
// two fractions, every operand and every fraction result reduced to lowest
// terms by binary gcd. One word at a time; a word with a bad op or a zero
// denominator goes straight to the result. The work is done by the
// bit-serial restoring divider (two quotients per reduction, up to three
// reductions), the shared shift-subtract gcd engine (data dependent) and the
// bit-serial multiplier (up to three products).
// Depends on rau_pkg and rational_arith_unit_macros.svh.
module rational_arith_unit #(
  parameter int unsigned VALUE_BITS = rau_pkg::ValueBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rau_pkg::out_t out_data_o
);
  import rau_pkg::*;

  localparam int unsigned W  = VALUE_BITS;
  localparam int unsigned DW = 2 * W;
  localparam int unsigned SW = $clog2(DW);
  localparam int unsigned MW = $clog2(W);
  localparam logic [DW-1:0] Lim = DW'(1) << (W - 1);

  function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
    return v[W-1] ? (~v) + W'(1) : v;
  endfunction

  state_e state_q, state_d;
  phase_e phase_q;

  logic [2:0]    op_q;
  logic [W-1:0]  bn_raw_q, bd_raw_q;
  logic [W-1:0]  am_q, adn_q, bm_q, bdn_q;
  logic          aneg_q, bneg_q;
  logic [DW-1:0] rm_q, rd_q;
  logic          rneg_q;
  logic [DW-1:0] gx_q, gy_q;
  logic [SW-1:0] gsh_q;
  logic [DW-1:0] dq_q, drem_q;
  logic [SW-1:0] dcnt_q;
  logic          dsel_q;
  logic [DW-1:0] mc_q, acc_q;
  logic [W-1:0]  ml_q;
  logic [MW-1:0] mcnt_q;
  logic [1:0]    k_q;
  logic [DW-1:0] p_q [3];
  logic signed [31:0] rnum_q;
  logic [30:0]   rden_q;
  logic          cmp_q;
  logic [1:0]    st_q;

  logic [W-1:0] in_an, in_ad;
  assign in_an = in_data_i.a_num[W-1:0];
  assign in_ad = in_data_i.a_den[W-1:0];

  logic accept, bad_op, zero_den;
  assign accept   = in_valid_i && in_ready_o;
  assign bad_op   = in_data_i.op > OpEq;
  assign zero_den = (in_ad == '0) || (in_data_i.b_den[W-1:0] == '0);

  // divider step
  logic [DW:0]   rem_sh;
  logic          div_ge;
  logic [DW-1:0] rem_nx, quo_nx;
  assign rem_sh = {drem_q, dq_q[DW-1]};
  assign div_ge = rem_sh >= {1'b0, gx_q};
  assign rem_nx = div_ge ? DW'(rem_sh - {1'b0, gx_q}) : rem_sh[DW-1:0];
  assign quo_nx = {dq_q[DW-2:0], div_ge};
  logic div_last;
  assign div_last = dcnt_q == SW'(DW - 1);

  // multiplier step
  logic [DW-1:0] acc_nx;
  assign acc_nx = ml_q[0] ? acc_q + mc_q : acc_q;
  logic mul_last, k_last;
  assign mul_last = mcnt_q == MW'(W - 1);
  assign k_last = (op_q == OpAdd || op_q == OpSub) ? (k_q == 2'd2) : (k_q == 2'd1);

  logic [W-1:0] mx, my;
  always_comb begin
    unique case (k_q)
      2'd0: begin
        mx = am_q;
        my = (op_q == OpMul) ? bm_q : bdn_q;
      end
      2'd1: begin
        mx = (op_q == OpMul || op_q == OpDiv) ? adn_q : bm_q;
        my = (op_q == OpMul) ? bdn_q : (op_q == OpDiv) ? bm_q : adn_q;
      end
      default: begin
        mx = adn_q;
        my = bdn_q;
      end
    endcase
  end

  logic fits;
  logic [W-1:0] rnum_w;
  assign fits = (rneg_q ? (rm_q <= Lim) : (rm_q < Lim)) && (rd_q < Lim);
  assign rnum_w = rneg_q ? (~rm_q[W-1:0]) + W'(1) : rm_q[W-1:0];

  logic signed [DW:0] lt_l, lt_r;
  assign lt_l = aneg_q ? -$signed({1'b0, p_q[0]}) : $signed({1'b0, p_q[0]});
  assign lt_r = bneg_q ? -$signed({1'b0, p_q[1]}) : $signed({1'b0, p_q[1]});

  logic          sub_yn;
  logic [DW-1:0] p0, p1;
  assign p0 = p_q[0];
  assign p1 = p_q[1];
  assign sub_yn = (op_q == OpSub) ? !bneg_q : bneg_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = (bad_op || zero_den) ? S_OUT : S_RED;
      end
      S_RED:   state_d = (rm_q == '0) ? S_NEXT : S_GTWO;
      S_GTWO:  if (gx_q[0] || gy_q[0]) state_d = S_GXODD;
      S_GXODD: if (gx_q[0]) state_d = S_GLOOP;
      S_GLOOP: if (gy_q == '0) state_d = S_GSHL;
      S_GSHL:  if (gsh_q == '0) state_d = S_DIV;
      S_DIV:   if (div_last && dsel_q) state_d = S_NEXT;
      S_NEXT: begin
        priority case (phase_q)
          PH_A: state_d = S_RED;
          PH_B: begin
            if (op_q == OpEq || (op_q == OpDiv && rm_q == '0)) state_d = S_OUT;
            else state_d = S_MLOAD;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_MLOAD: state_d = S_MUL;
      S_MUL:   if (mul_last) state_d = k_last ? S_COMB : S_MLOAD;
      S_COMB:  state_d = (op_q == OpLt) ? S_OUT : S_RED;
      S_OUT:   if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = state_q == S_IDLE;
    out_valid_o = state_q == S_OUT;
    out_data_o.res_num  = rnum_q;
    out_data_o.res_den  = rden_q;
    out_data_o.cmp_true = cmp_q;
    out_data_o.status   = st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q     <= in_data_i.op;
          bn_raw_q <= in_data_i.b_num[W-1:0];
          bd_raw_q <= in_data_i.b_den[W-1:0];
          rm_q     <= DW'(mag_w(in_an));
          rd_q     <= DW'(mag_w(in_ad));
          rneg_q   <= in_an[W-1] ^ in_ad[W-1];
          phase_q  <= PH_A;
          rnum_q   <= '0;
          rden_q   <= '0;
          cmp_q    <= 1'b0;
          st_q     <= (!bad_op && zero_den) ? StZeroDen : StOk;
        end
      end
      S_RED: begin
        if (rm_q == '0) begin
          rd_q   <= DW'(1);
          rneg_q <= 1'b0;
        end
        gx_q  <= rm_q;
        gy_q  <= rd_q;
        gsh_q <= '0;
      end
      S_GTWO: begin
        if (!gx_q[0] && !gy_q[0]) begin
          gx_q  <= gx_q >> 1;
          gy_q  <= gy_q >> 1;
          gsh_q <= gsh_q + SW'(1);
        end
      end
      S_GXODD: if (!gx_q[0]) gx_q <= gx_q >> 1;
      S_GLOOP: begin
        if (gy_q != '0) begin
          if (!gy_q[0]) begin
            gy_q <= gy_q >> 1;
          end else if (gx_q > gy_q) begin
            gx_q <= gy_q;
            gy_q <= gx_q - gy_q;
          end else begin
            gy_q <= gy_q - gx_q;
          end
        end
      end
      S_GSHL: begin
        // restore the common power of two, divider setup on the way out
        if (gsh_q != '0) begin
          gx_q  <= gx_q << 1;
          gsh_q <= gsh_q - SW'(1);
        end
        dq_q   <= rm_q;
        drem_q <= '0;
        dcnt_q <= '0;
        dsel_q <= 1'b0;
      end
      S_DIV: begin
        if (div_last) begin
          drem_q <= '0;
          dcnt_q <= '0;
          if (!dsel_q) begin
            rm_q   <= quo_nx;
            dq_q   <= rd_q;
            dsel_q <= 1'b1;
          end else begin
            rd_q <= quo_nx;
            dq_q <= quo_nx;
          end
        end else begin
          drem_q <= rem_nx;
          dq_q   <= quo_nx;
          dcnt_q <= dcnt_q + SW'(1);
        end
      end
      S_NEXT: begin
        priority case (phase_q)
          PH_A: begin
            am_q    <= rm_q[W-1:0];
            adn_q   <= rd_q[W-1:0];
            aneg_q  <= rneg_q;
            rm_q    <= DW'(mag_w(bn_raw_q));
            rd_q    <= DW'(mag_w(bd_raw_q));
            rneg_q  <= bn_raw_q[W-1] ^ bd_raw_q[W-1];
            phase_q <= PH_B;
          end
          PH_B: begin
            bm_q   <= rm_q[W-1:0];
            bdn_q  <= rd_q[W-1:0];
            bneg_q <= rneg_q;
            k_q    <= '0;
            if (op_q == OpEq) begin
              cmp_q <= (aneg_q == rneg_q) && (am_q == rm_q[W-1:0])
                       && (adn_q == rd_q[W-1:0]);
            end else if (op_q == OpDiv && rm_q == '0) begin
              st_q <= StDivZero;
            end
          end
          default: begin
            if (fits) begin
              rnum_q <= 32'($signed(rnum_w));
              rden_q <= 31'(rd_q[W-2:0]);
            end else begin
              st_q <= StOverflow;
            end
          end
        endcase
      end
      S_MLOAD: begin
        mc_q   <= DW'(mx);
        ml_q   <= my;
        acc_q  <= '0;
        mcnt_q <= '0;
      end
      S_MUL: begin
        acc_q  <= acc_nx;
        mc_q   <= mc_q << 1;
        ml_q   <= ml_q >> 1;
        mcnt_q <= mcnt_q + MW'(1);
        if (mul_last) begin
          p_q[k_q] <= acc_nx;
          k_q      <= k_q + 2'd1;
        end
      end
      S_COMB: begin
        phase_q <= PH_R;
        if (op_q == OpLt) begin
          cmp_q <= lt_l < lt_r;
        end else if (op_q == OpAdd || op_q == OpSub) begin
          rd_q <= p_q[2];
          if (aneg_q == sub_yn) begin
            rneg_q <= aneg_q;
            rm_q   <= p0 + p1;
          end else if (p0 >= p1) begin
            rneg_q <= aneg_q;
            rm_q   <= p0 - p1;
          end else begin
            rneg_q <= sub_yn;
            rm_q   <= p1 - p0;
          end
        end else begin
          rneg_q <= aneg_q ^ bneg_q;
          rm_q   <= p0;
          rd_q   <= p1;
        end
      end
      default: ;
    endcase
  end

`include "rational_arith_unit_macros.svh"

  `RAU_ASSERT(a_one_word, !(out_valid_o && in_ready_o), "accepting while result pending")
  `RAU_ASSERT_IMP(a_err_zero, out_valid_o && (out_data_o.status != StOk), (out_data_o.res_num == 0) && (out_data_o.res_den == 0), "fraction not cleared on error")
  `RAU_ASSERT_IMP(a_cmp_nofrac, out_valid_o && out_data_o.cmp_true, (out_data_o.res_num == 0) && (out_data_o.status == StOk), "compare result carries a fraction")
  `RAU_ASSERT_NXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o, "ready held after accept")

endmodule
